// ===== hdl/sfrd_pkg.sv =====
// sfrd_pkg: shared types and constants of the sorted flow record dedupe unit
// record layout, configuration register set, command and register index codes
// no dependencies
`default_nettype none

package sfrd_pkg;

   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [31:0] nhip;
      logic [31:0] ports;
      logic [31:0] proto_flags;
      logic [31:0] packets;
      logic [31:0] bytes_count;
      logic [47:0] start_time;
      logic [31:0] elapsed;
      logic [31:0] sensor_type_state;
      logic [47:0] ifaces_app;
   } rec_type;

   typedef struct packed {
      logic [18:0] field_mask;
      logic [31:0] delta_packets;
      logic [31:0] delta_bytes;
      logic [47:0] delta_start_time;
      logic [31:0] delta_elapsed;
   } cfg_type;

   typedef enum logic [0:0] {
      CMD_RECORD = 1'b0,
      CMD_END    = 1'b1
   } cmd_type;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 48;

   localparam logic [CsrIndexWidth-1:0] CSR_FIELD_MASK       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DELTA_PACKETS    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DELTA_BYTES      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DELTA_START_TIME = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_DELTA_ELAPSED    = 3'd4;

   // key field bits of field_mask
   localparam int FB_SIP        = 0;
   localparam int FB_DIP        = 1;
   localparam int FB_NHIP       = 2;
   localparam int FB_SPORT      = 3;
   localparam int FB_DPORT      = 4;
   localparam int FB_PROTO      = 5;
   localparam int FB_PACKETS    = 6;
   localparam int FB_BYTES      = 7;
   localparam int FB_FLAGS      = 8;
   localparam int FB_START      = 9;
   localparam int FB_ELAPSED    = 10;
   localparam int FB_SENSOR     = 11;
   localparam int FB_IN_IFACE   = 12;
   localparam int FB_OUT_IFACE  = 13;
   localparam int FB_INIT_FLAGS = 14;
   localparam int FB_REST_FLAGS = 15;
   localparam int FB_TCP_STATE  = 16;
   localparam int FB_APP        = 17;
   localparam int FB_FLOW_TYPE  = 18;

endpackage

`default_nettype wire

// ===== hdl/sfrd_compare.sv =====
// sfrd_compare: decides whether an arriving record matches the kept record
// masked exact compares plus delta windows on counts and times
// depends on sfrd_pkg
`default_nettype none

module sfrd_compare
   import sfrd_pkg::*;
(
   input  var rec_type new_rec,
   input  var rec_type held_rec,
   input  var cfg_type cfg,
   output logic        match
);

   function automatic logic near48(input logic [47:0] a, input logic [47:0] b,
                                   input logic [47:0] d);
      logic [47:0] diff;
      begin
         diff = (a > b) ? (a - b) : (b - a);
         return diff <= d;
      end
   endfunction

   logic [18:0] eq;
   logic [18:0] m;

   assign m = cfg.field_mask;

   always_comb begin
      eq[FB_SIP]        = new_rec.sip == held_rec.sip;
      eq[FB_DIP]        = new_rec.dip == held_rec.dip;
      eq[FB_NHIP]       = new_rec.nhip == held_rec.nhip;
      eq[FB_SPORT]      = new_rec.ports[31:16] == held_rec.ports[31:16];
      eq[FB_DPORT]      = new_rec.ports[15:0] == held_rec.ports[15:0];
      eq[FB_PROTO]      = new_rec.proto_flags[31:24] == held_rec.proto_flags[31:24];
      eq[FB_PACKETS]    = near48({16'd0, new_rec.packets}, {16'd0, held_rec.packets},
                                 {16'd0, cfg.delta_packets});
      eq[FB_BYTES]      = near48({16'd0, new_rec.bytes_count},
                                 {16'd0, held_rec.bytes_count},
                                 {16'd0, cfg.delta_bytes});
      eq[FB_FLAGS]      = new_rec.proto_flags[23:16] == held_rec.proto_flags[23:16];
      eq[FB_START]      = near48(new_rec.start_time, held_rec.start_time,
                                 cfg.delta_start_time);
      eq[FB_ELAPSED]    = near48({16'd0, new_rec.elapsed}, {16'd0, held_rec.elapsed},
                                 {16'd0, cfg.delta_elapsed});
      eq[FB_SENSOR]     = new_rec.sensor_type_state[31:16] ==
                          held_rec.sensor_type_state[31:16];
      eq[FB_IN_IFACE]   = new_rec.ifaces_app[47:32] == held_rec.ifaces_app[47:32];
      eq[FB_OUT_IFACE]  = new_rec.ifaces_app[31:16] == held_rec.ifaces_app[31:16];
      eq[FB_INIT_FLAGS] = new_rec.proto_flags[15:8] == held_rec.proto_flags[15:8];
      eq[FB_REST_FLAGS] = new_rec.proto_flags[7:0] == held_rec.proto_flags[7:0];
      eq[FB_TCP_STATE]  = new_rec.sensor_type_state[7:0] ==
                          held_rec.sensor_type_state[7:0];
      eq[FB_APP]        = new_rec.ifaces_app[15:0] == held_rec.ifaces_app[15:0];
      eq[FB_FLOW_TYPE]  = new_rec.sensor_type_state[15:8] ==
                          held_rec.sensor_type_state[15:8];
   end

   // empty mask means the whole record must be identical
   assign match = (m == '0) ? (new_rec == held_rec) : ((eq | ~m) == '1);

endmodule

`default_nettype wire

// ===== hdl/sfrd_skid.sv =====
// sfrd_skid: output register plus one skid entry for emitted records
// the upstream stall comes straight from a flop
// depends on sfrd_pkg
`default_nettype none

module sfrd_skid
   import sfrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  var rec_type in_data,
   output logic    in_stall,
   output logic    out_valid,
   input  logic    out_stall,
   output rec_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rec_type out_data_ff, out_data_in;
   rec_type skid_data_ff, skid_data_in;
   logic    take;

   assign take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no new transaction can arrive while the skid entry is full
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== hdl/sorted_flow_record_dedupe_unit.sv =====
// sorted_flow_record_dedupe_unit: top level of the adjacent duplicate remover
// holds the kept record and configuration, instantiates sfrd_compare and sfrd_skid
// depends on sfrd_pkg
//
// usage:
//   req_* carries one command per transaction: a flow record (req_cmd = 0) or an
//   end-of-stream flush (req_cmd = 1). the records must arrive sorted on the
//   compared keys. each record is checked against the kept record in the cycle
//   it is accepted; a differing record pushes the kept one out on rsp_* and takes
//   its place, a matching one is dropped. a flush pushes out the kept record and
//   leaves the holder empty.
//   a result is registered in the output register, or in the skid entry when
//   rsp_stall holds that register. throughput: one transaction per cycle while
//   req_stall is low; the compare is one pass of equality and 48-bit window
//   logic between the kept-record register and the output register.
//   stall: the output register has one skid entry behind it; req_stall rises
//   only once that entry is filled, i.e. after rsp_stall held a result back
//   while another one was produced.
//   reset empties the holder and the output side and zeroes every csr. csr writes
//   are always taken (csr_ready is high) and must happen while the unit is idle.
`default_nettype none

module sorted_flow_record_dedupe_unit
   import sfrd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // record channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [0:0]               req_cmd,
   input  logic [31:0]              req_sip,
   input  logic [31:0]              req_dip,
   input  logic [31:0]              req_nhip,
   input  logic [31:0]              req_ports,
   input  logic [31:0]              req_proto_flags,
   input  logic [31:0]              req_packets,
   input  logic [31:0]              req_bytes_count,
   input  logic [47:0]              req_start_time,
   input  logic [31:0]              req_elapsed,
   input  logic [31:0]              req_sensor_type_state,
   input  logic [47:0]              req_ifaces_app,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_out_sip,
   output logic [31:0]              rsp_out_dip,
   output logic [31:0]              rsp_out_nhip,
   output logic [31:0]              rsp_out_ports,
   output logic [31:0]              rsp_out_proto_flags,
   output logic [31:0]              rsp_out_packets,
   output logic [31:0]              rsp_out_bytes_count,
   output logic [47:0]              rsp_out_start_time,
   output logic [31:0]              rsp_out_elapsed,
   output logic [31:0]              rsp_out_sensor_type_state,
   output logic [47:0]              rsp_out_ifaces_app,
   // csr write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    held_valid_ff, held_valid_in;
   rec_type held_rec_ff, held_rec_in;
   rec_type new_rec;
   rec_type rsp_rec;
   logic    accept;
   logic    is_end;
   logic    match;
   logic    emit;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FIELD_MASK:       cfg_in.field_mask       = csr_data[18:0];
            CSR_DELTA_PACKETS:    cfg_in.delta_packets    = csr_data[31:0];
            CSR_DELTA_BYTES:      cfg_in.delta_bytes      = csr_data[31:0];
            CSR_DELTA_START_TIME: cfg_in.delta_start_time = csr_data[47:0];
            CSR_DELTA_ELAPSED:    cfg_in.delta_elapsed    = csr_data[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   assign new_rec = '{sip: req_sip, dip: req_dip, nhip: req_nhip, ports: req_ports,
                      proto_flags: req_proto_flags, packets: req_packets,
                      bytes_count: req_bytes_count, start_time: req_start_time,
                      elapsed: req_elapsed, sensor_type_state: req_sensor_type_state,
                      ifaces_app: req_ifaces_app};

   sfrd_compare u_compare (
      .new_rec  (new_rec),
      .held_rec (held_rec_ff),
      .cfg      (cfg_ff),
      .match    (match)
   );

   assign accept = req_valid && !req_stall;
   assign is_end = req_cmd == CMD_END;
   assign emit   = accept && held_valid_ff && (is_end || !match);

   always_comb begin
      held_valid_in = held_valid_ff;
      held_rec_in   = held_rec_ff;
      if (accept) begin
         if (is_end) begin
            held_valid_in = 1'b0;
         end else if (!held_valid_ff || !match) begin
            held_valid_in = 1'b1;
            held_rec_in   = new_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         held_valid_ff <= held_valid_in;
      end
      held_rec_ff <= held_rec_in;
   end

   sfrd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit),
      .in_data   (held_rec_ff),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_rec)
   );

   assign rsp_out_sip               = rsp_rec.sip;
   assign rsp_out_dip               = rsp_rec.dip;
   assign rsp_out_nhip              = rsp_rec.nhip;
   assign rsp_out_ports             = rsp_rec.ports;
   assign rsp_out_proto_flags       = rsp_rec.proto_flags;
   assign rsp_out_packets           = rsp_rec.packets;
   assign rsp_out_bytes_count       = rsp_rec.bytes_count;
   assign rsp_out_start_time        = rsp_rec.start_time;
   assign rsp_out_elapsed           = rsp_rec.elapsed;
   assign rsp_out_sensor_type_state = rsp_rec.sensor_type_state;
   assign rsp_out_ifaces_app        = rsp_rec.ifaces_app;

   // a full skid entry always sits behind a full output register
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output register");

   // the skid entry only fills while a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("skid entry filled without a stalled result");

   // a flush always empties the holder
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && is_end) |=> !held_valid_ff)
      else $error("holder not empty after flush");

   // a record transaction always leaves something held
   a_record_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_end) |=> held_valid_ff)
      else $error("holder empty after record transaction");

endmodule

`default_nettype wire
